[src/pol_pkg.sv]
// ----------------------------------------------------------------------------
// Positional ordered list package
// Shared constants and command and status codes for the ordered list block.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LEN_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CNT_W    = (LEN_W > POS_W) ? LEN_W : POS_W;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

endpackage

[src/pol_store.sv]
// ----------------------------------------------------------------------------
// Ordered list entry store
// Single-port write, single-port registered read memory for list entries.
// ----------------------------------------------------------------------------
module pol_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [pol_pkg::ADDR_W-1:0] waddr_i,
  input  logic [pol_pkg::DATA_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [pol_pkg::ADDR_W-1:0] raddr_i,
  output logic [pol_pkg::DATA_W-1:0] rdata_o
);

  logic [pol_pkg::DATA_W-1:0] mem_q [pol_pkg::CAPACITY];
  logic [pol_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/positional_ordered_list_unit.sv]
// ----------------------------------------------------------------------------
// Insert moves each entry from the position upward by one place, a read then a
// write per entry, then writes the new value; delete moves each later entry down
// likewise; dump reads and then presents each entry. Receiver stalls hold the
// result register. One transaction at a time: a new one is taken only in idle.
// Reset clears the length and control state; the entry store is not cleared.
// ----------------------------------------------------------------------------
// Positional ordered list unit
// Bounded ordered list with insert, delete and dump, over a sequenced store.
// ----------------------------------------------------------------------------
module positional_ordered_list_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        cmd_i,
  input  logic [pol_pkg::POS_W-1:0]         position_i,
  input  logic signed [pol_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic signed [pol_pkg::DATA_W-1:0] entry_value_o,
  output logic [pol_pkg::POS_W-1:0]         entry_index_o,
  output logic                              last_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_WR   = 3'd2;
  localparam logic [2:0] S_DEL_RD   = 3'd3;
  localparam logic [2:0] S_DEL_WR   = 3'd4;
  localparam logic [2:0] S_DUMP_RD  = 3'd5;
  localparam logic [2:0] S_DUMP_OUT = 3'd6;
  localparam logic [2:0] S_RESP     = 3'd7;

  localparam int unsigned CW = pol_pkg::CNT_W;
  localparam int unsigned AW = pol_pkg::ADDR_W;
  localparam int unsigned DW = pol_pkg::DATA_W;

  logic [2:0]              state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [CW-1:0]           at_q, at_d;
  logic [pol_pkg::LEN_W-1:0] len_q, len_d;
  logic [DW-1:0]           val_q, val_d;
  logic [1:0]              status_q, status_d;

  logic                    out_valid_q, out_valid_d;
  logic [1:0]              out_status_q, out_status_d;
  logic [DW-1:0]           out_value_q, out_value_d;
  logic [pol_pkg::POS_W-1:0] out_index_q, out_index_d;
  logic                    out_last_q, out_last_d;

  logic                    we, re;
  logic [AW-1:0]           waddr, raddr;
  logic [DW-1:0]           wdata, rdata;

  logic [CW-1:0]           len_ext, pos_ext, cnt_inc, cnt_dec, ins_at;
  logic                    accept, out_free, load;

  assign len_ext  = CW'(len_q);
  assign pos_ext  = CW'(position_i);
  assign cnt_inc  = cnt_q + CW'(1);
  assign cnt_dec  = cnt_q - CW'(1);
  assign ins_at   = (len_q == '0) ? '0 : pos_ext;
  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  pol_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    at_d         = at_q;
    len_d        = len_q;
    val_d        = val_q;
    status_d     = status_q;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = cnt_q[AW-1:0];
    wdata        = rdata;
    raddr        = cnt_q[AW-1:0];
    load         = 1'b0;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_index_d  = out_index_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i)
            pol_pkg::CMD_INSERT: begin
              if (len_q == pol_pkg::LEN_W'(pol_pkg::CAPACITY)) begin
                status_d = pol_pkg::ST_FULL;
                state_d  = S_RESP;
              end else if (ins_at > len_ext) begin
                status_d = pol_pkg::ST_RANGE;
                state_d  = S_RESP;
              end else begin
                at_d    = ins_at;
                cnt_d   = len_ext;
                val_d   = value_i;
                state_d = S_INS_RD;
              end
            end
            pol_pkg::CMD_DELETE: begin
              if (len_q == '0) begin
                status_d = pol_pkg::ST_EMPTY;
                state_d  = S_RESP;
              end else if (pos_ext >= len_ext) begin
                status_d = pol_pkg::ST_RANGE;
                state_d  = S_RESP;
              end else begin
                cnt_d   = pos_ext;
                state_d = S_DEL_RD;
              end
            end
            pol_pkg::CMD_DUMP: begin
              if (len_q == '0) begin
                status_d = pol_pkg::ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                cnt_d   = '0;
                state_d = S_DUMP_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (cnt_q > at_q) begin
          re      = 1'b1;
          raddr   = cnt_dec[AW-1:0];
          state_d = S_INS_WR;
        end else begin
          we       = 1'b1;
          waddr    = at_q[AW-1:0];
          wdata    = val_q;
          len_d    = len_q + pol_pkg::LEN_W'(1);
          status_d = pol_pkg::ST_OK;
          state_d  = S_RESP;
        end
      end
      S_INS_WR: begin
        we      = 1'b1;
        cnt_d   = cnt_dec;
        state_d = S_INS_RD;
      end
      S_DEL_RD: begin
        if (cnt_inc < len_ext) begin
          re      = 1'b1;
          raddr   = cnt_inc[AW-1:0];
          state_d = S_DEL_WR;
        end else begin
          len_d    = len_q - pol_pkg::LEN_W'(1);
          status_d = pol_pkg::ST_OK;
          state_d  = S_RESP;
        end
      end
      S_DEL_WR: begin
        we      = 1'b1;
        cnt_d   = cnt_inc;
        state_d = S_DEL_RD;
      end
      S_DUMP_RD: begin
        re      = 1'b1;
        state_d = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (out_free) begin
          load         = 1'b1;
          out_status_d = pol_pkg::ST_OK;
          out_value_d  = rdata;
          out_index_d  = cnt_q[pol_pkg::POS_W-1:0];
          out_last_d   = (cnt_inc == len_ext);
          cnt_d        = cnt_inc;
          state_d      = (cnt_inc == len_ext) ? S_IDLE : S_DUMP_RD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          load         = 1'b1;
          out_status_d = status_q;
          out_value_d  = '0;
          out_index_d  = '0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    at_q         <= at_d;
    val_q        <= val_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_index_q  <= out_index_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_value_o = out_value_q;
  assign entry_index_o = out_index_q;
  assign last_o        = out_last_q;

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Ordered list unit testbench
// Drives insert, delete, dump and no-op transactions into the ordered list block,
// under random sender bursts and receiver stalls. A shadow list predicts
// every status and dump entry, and the results are checked in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 430;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned DRAIN_CYCLES = 2 * pol_pkg::CAPACITY + 8;

  typedef struct packed {
    pol_pkg::cmd_e                     cmd;
    logic [pol_pkg::POS_W-1:0]         pos;
    logic signed [pol_pkg::DATA_W-1:0] val;
  } list_req_t;

  typedef struct packed {
    pol_pkg::status_e                  status;
    logic signed [pol_pkg::DATA_W-1:0] val;
    logic [pol_pkg::POS_W-1:0]         idx;
    logic                              last;
  } list_result_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic [1:0]                        cmd_i = pol_pkg::CMD_INSERT;
  logic [pol_pkg::POS_W-1:0]         position_i = '0;
  logic signed [pol_pkg::DATA_W-1:0] value_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic [1:0]                        status_o;
  logic signed [pol_pkg::DATA_W-1:0] entry_value_o;
  logic [pol_pkg::POS_W-1:0]         entry_index_o;
  logic                              last_o;

  list_req_t                         stim_q[$];
  list_result_t                      due_results[$];
  logic signed [pol_pkg::DATA_W-1:0] list_shadow[$];

  int unsigned stim_total = 0;
  int unsigned accepted_count = 0;
  int unsigned fail_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gen_len = 0;
  logic        in_taken = 1'b0;

  positional_ordered_list_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .entry_value_o (entry_value_o),
    .entry_index_o (entry_index_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic void push_status(pol_pkg::status_e st);
    due_results.push_back('{st, '0, '0, 1'b1});
  endfunction

  function automatic void apply_list_op(pol_pkg::cmd_e op, logic [pol_pkg::POS_W-1:0] pos,
                                        logic signed [pol_pkg::DATA_W-1:0] val);
    int unsigned len;
    int unsigned at;
    len = list_shadow.size();
    case (op)
      pol_pkg::CMD_INSERT: begin
        at = (len == 0) ? 0 : pos;
        if (len >= pol_pkg::CAPACITY) begin
          push_status(pol_pkg::ST_FULL);
        end else if (at > len) begin
          push_status(pol_pkg::ST_RANGE);
        end else begin
          list_shadow.insert(at, val);
          push_status(pol_pkg::ST_OK);
        end
      end
      pol_pkg::CMD_DELETE: begin
        if (len == 0) begin
          push_status(pol_pkg::ST_EMPTY);
        end else if (pos >= len) begin
          push_status(pol_pkg::ST_RANGE);
        end else begin
          list_shadow.delete(pos);
          push_status(pol_pkg::ST_OK);
        end
      end
      pol_pkg::CMD_DUMP: begin
        if (len == 0) begin
          push_status(pol_pkg::ST_EMPTY);
        end else begin
          for (int i = 0; i < len; i++) begin
            due_results.push_back('{pol_pkg::ST_OK, list_shadow[i],
                                    pol_pkg::POS_W'(i), i == len - 1});
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Queue a transaction and track the length it leaves behind
  task automatic queue_req(pol_pkg::cmd_e op, int unsigned pos,
                           logic signed [pol_pkg::DATA_W-1:0] val);
    int unsigned at;
    at = (gen_len == 0) ? 0 : pos;
    stim_q.push_back('{op, pol_pkg::POS_W'(pos), val});
    stim_total++;
    if (op == pol_pkg::CMD_INSERT && gen_len < pol_pkg::CAPACITY && at <= gen_len) begin
      gen_len++;
    end else if (op == pol_pkg::CMD_DELETE && gen_len != 0 && pos < gen_len) begin
      gen_len--;
    end
  endtask

  // Sender: bursts of transactions separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin : drive_in
    list_req_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      // hold until accepted
    end else if (gap_left != 0) begin
      in_valid_i <= 1'b0;
      gap_left = gap_left - 1;
    end else if (stim_q.size() != 0) begin
      req = stim_q.pop_front();
      in_valid_i <= 1'b1;
      cmd_i      <= req.cmd;
      position_i <= req.pos;
      value_i    <= req.val;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(40, 1);
        gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      end else begin
        burst_left = burst_left - 1;
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver: stall on a rotating pattern, reloaded now and then
  logic [15:0] stall_pat = 16'hffff;
  int unsigned stall_timer = 0;

  always @(negedge clk_i) begin
    if (stall_timer == 0) begin
      case ($urandom_range(2, 0))
        0:       stall_pat = 16'hffff;
        1:       stall_pat = 16'($urandom()) | 16'h0001;
        default: stall_pat = 16'($urandom() & $urandom()) | 16'h0001;
      endcase
      stall_timer = $urandom_range(300, 50);
    end
    stall_timer = stall_timer - 1;
    out_ready_i <= rst_ni && stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[15:1]};
  end

  always @(posedge clk_i) begin : watch_ports
    list_result_t want;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        in_taken = 1'b1;
        accepted_count++;
        apply_list_op(pol_pkg::cmd_e'(cmd_i), position_i, value_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result: status %0d value %0d index %0d last %0b",
                     status_o, entry_value_o, entry_index_o, last_o);
          end
        end else begin
          want = due_results.pop_front();
          if (status_o !== want.status || entry_value_o !== want.val ||
              entry_index_o !== want.idx || last_o !== want.last) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected status %0d value %0d index %0d last %0b",
                       want.status, want.val, want.idx, want.last);
              $display("          actual   status %0d value %0d index %0d last %0b",
                       status_o, entry_value_o, entry_index_o, last_o);
            end
          end
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned seg;
    int unsigned r;

    queue_req(pol_pkg::CMD_DUMP, 0, 0);
    queue_req(pol_pkg::CMD_DELETE, 0, 0);
    queue_req(pol_pkg::CMD_INSERT, 63, 32'sh7fffffff);
    queue_req(pol_pkg::CMD_INSERT, 0, 32'sh80000000);
    queue_req(pol_pkg::CMD_INSERT, 2, -1);
    queue_req(pol_pkg::CMD_INSERT, 5, 0);
    queue_req(pol_pkg::CMD_INSERT, 1, 32'sh12345678);
    queue_req(pol_pkg::CMD_DUMP, 0, 0);
    queue_req(pol_pkg::CMD_DELETE, 4, 0);
    queue_req(pol_pkg::CMD_DELETE, 63, 0);
    queue_req(pol_pkg::CMD_DELETE, 1, 0);
    queue_req(pol_pkg::CMD_NONE, 63, -1);
    queue_req(pol_pkg::CMD_DELETE, 2, 0);
    queue_req(pol_pkg::CMD_DUMP, 63, -1);
    queue_req(pol_pkg::CMD_DELETE, 0, 0);
    queue_req(pol_pkg::CMD_DELETE, 0, 0);
    queue_req(pol_pkg::CMD_DUMP, 0, 0);
    queue_req(pol_pkg::CMD_INSERT, 0, 0);

    // grow, shrink, mix, or fill to capacity and push past it
    while (stim_total < RANDOM_ITEMS) begin
      phase = $urandom_range(3, 0);
      seg   = (phase == 3) ? pol_pkg::CAPACITY + 8 : $urandom_range(40, 5);
      repeat (seg) begin
        r = $urandom_range(99, 0);
        if (r < 6) begin
          queue_req(pol_pkg::CMD_DUMP, $urandom_range(63, 0), $urandom());
        end else if (r < 12) begin
          queue_req(pol_pkg::cmd_e'($urandom_range(3, 0)), $urandom_range(63, 0),
                    $urandom());
        end else if (phase == 0 || phase == 3 || (phase == 2 && r < 56)) begin
          queue_req(pol_pkg::CMD_INSERT, $urandom_range(gen_len, 0), $urandom());
        end else if (gen_len != 0) begin
          queue_req(pol_pkg::CMD_DELETE, $urandom_range(gen_len - 1, 0), $urandom());
        end else begin
          queue_req(pol_pkg::CMD_DELETE, $urandom_range(63, 0), $urandom());
        end
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_count < stim_total || due_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
src/pol_pkg.sv
src/pol_store.sv
src/positional_ordered_list_unit.sv
tb/sv/tb_top.sv
